/* sv/ttace_pkg.sv */
package ttace_pkg;

   localparam int NUM_SLOTS_DEFAULT = 16;
   localparam int ID_W              = 4;
   localparam int TICK_W            = 32;

   localparam logic [1:0] OP_ARM    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_POLL   = 2'd2;

   typedef enum logic [1:0] {
      KIND_ARM    = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_FIRED  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic arm;
      logic cancel;
      logic poll_init;
      logic lookup;
      logic check;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } ctl_status_type;

endpackage

/* sv/ttace_ram.sv */
module ttace_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/ttace_ctrl.sv */
module ttace_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                opcode,
   input  ttace_pkg::ctl_status_type status,
   output ttace_pkg::ctl_cmd_type    cmd,
   output logic                      busy
);

   ttace_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttace_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttace_pkg::ST_IDLE: begin
            if (start && opcode == ttace_pkg::OP_POLL) begin
               state_in = ttace_pkg::ST_LOOK;
            end
         end
         ttace_pkg::ST_LOOK: begin
            state_in = status.scan_done ? ttace_pkg::ST_IDLE : ttace_pkg::ST_CHECK;
         end
         ttace_pkg::ST_CHECK: begin
            state_in = ttace_pkg::ST_LOOK;
         end
         default: begin
            state_in = ttace_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ttace_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               unique case (opcode)
                  ttace_pkg::OP_ARM:    cmd.arm       = 1'b1;
                  ttace_pkg::OP_CANCEL: cmd.cancel    = 1'b1;
                  ttace_pkg::OP_POLL:   cmd.poll_init = 1'b1;
                  default: ;
               endcase
            end
         end
         ttace_pkg::ST_LOOK: begin
            if (status.scan_done) begin
               cmd.finish = 1'b1;
            end else begin
               cmd.lookup = 1'b1;
            end
         end
         ttace_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

/* sv/ttace_dp.sv */
module ttace_dp #(
   parameter int NUM_SLOTS = ttace_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ttace_pkg::ctl_cmd_type        cmd,
   output ttace_pkg::ctl_status_type     status,
   input  logic [ttace_pkg::ID_W-1:0]    req_timer_id,
   input  logic [ttace_pkg::TICK_W-1:0]  req_expiry_time,
   input  logic [ttace_pkg::TICK_W-1:0]  req_now_ticks,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_kind,
   output logic [ttace_pkg::ID_W-1:0]    rsp_slot_id,
   output logic                          rsp_prior_pending,
   output logic                          rsp_last
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int RW = $clog2(NUM_SLOTS);
   localparam int CW = $clog2(NUM_SLOTS + 1);

   logic [NUM_SLOTS-1:0]        pending_ff, pending_in;
   logic [RW-1:0]               rank_ff [NUM_SLOTS];
   logic [RW-1:0]               rank_in [NUM_SLOTS];
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [CW-1:0]               scan_ff, scan_in;
   logic [CW-1:0]               fired_ff, fired_in;
   logic [ttace_pkg::TICK_W-1:0] now_ff, now_in;
   logic [SW-1:0]               slot_ff, slot_in;
   logic                        hold_vld_ff, hold_vld_in;
   logic [SW-1:0]               hold_slot_ff, hold_slot_in;

   logic                        rsp_vld_ff, rsp_vld_in;
   ttace_pkg::kind_type         rsp_kind_ff, rsp_kind_in;
   logic [ttace_pkg::ID_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                        rsp_wp_ff, rsp_wp_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [SW-1:0]               idx;
   logic                        id_ok;
   logic                        was_pend;
   logic [SW-1:0]               lk_slot;
   logic                        ram_we;
   logic [ttace_pkg::TICK_W-1:0] ram_rdata;
   logic [ttace_pkg::TICK_W-1:0] diff;
   logic                        due;

   assign idx      = SW'(req_timer_id);
   assign id_ok    = {28'd0, req_timer_id} < 32'(NUM_SLOTS);
   assign was_pend = id_ok && pending_ff[idx];
   assign ram_we   = cmd.arm && id_ok;
   assign diff     = now_ff - ram_rdata;
   assign due      = !diff[ttace_pkg::TICK_W-1];

   assign status.scan_done = (scan_ff == cnt_ff);

   always_comb begin
      lk_slot = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (pending_ff[i] && rank_ff[i] == scan_ff[RW-1:0]) begin
            lk_slot = lk_slot | SW'(i);
         end
      end
   end

   ttace_ram #(
      .WIDTH (ttace_pkg::TICK_W),
      .DEPTH (NUM_SLOTS)
   ) u_expiry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx),
      .wr_data (req_expiry_time),
      .rd_addr (lk_slot),
      .rd_data (ram_rdata)
   );

   always_comb begin
      pending_in   = pending_ff;
      rank_in      = rank_ff;
      cnt_in       = cnt_ff;
      scan_in      = scan_ff;
      fired_in     = fired_ff;
      now_in       = now_ff;
      slot_in      = slot_ff;
      hold_vld_in  = hold_vld_ff;
      hold_slot_in = hold_slot_ff;
      rsp_vld_in   = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_wp_in    = rsp_wp_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.arm) begin
         if (id_ok && !was_pend) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (pending_ff[i]) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
            rank_in[idx]    = '0;
            pending_in[idx] = 1'b1;
            cnt_in          = cnt_ff + 1'b1;
         end
         rsp_vld_in  = 1'b1;
         rsp_kind_in = ttace_pkg::KIND_ARM;
         rsp_slot_in = req_timer_id;
         rsp_wp_in   = was_pend;
         rsp_last_in = 1'b1;
      end

      if (cmd.cancel) begin
         if (was_pend) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (pending_ff[i] && rank_ff[i] > rank_ff[idx]) begin
                  rank_in[i] = rank_ff[i] - 1'b1;
               end
            end
            rank_in[idx]    = '0;
            pending_in[idx] = 1'b0;
            cnt_in          = cnt_ff - 1'b1;
         end
         rsp_vld_in  = 1'b1;
         rsp_kind_in = ttace_pkg::KIND_CANCEL;
         rsp_slot_in = req_timer_id;
         rsp_wp_in   = was_pend;
         rsp_last_in = 1'b1;
      end

      if (cmd.poll_init) begin
         scan_in     = '0;
         fired_in    = '0;
         hold_vld_in = 1'b0;
         now_in      = req_now_ticks;
      end

      if (cmd.lookup) begin
         slot_in = lk_slot;
      end

      // survivors are renumbered in place as the scan passes them
      if (cmd.check) begin
         if (due) begin
            pending_in[slot_ff] = 1'b0;
            rank_in[slot_ff]    = '0;
            fired_in            = fired_ff + 1'b1;
            hold_vld_in         = 1'b1;
            hold_slot_in        = slot_ff;
            if (hold_vld_ff) begin
               rsp_vld_in  = 1'b1;
               rsp_kind_in = ttace_pkg::KIND_FIRED;
               rsp_slot_in = ttace_pkg::ID_W'(hold_slot_ff);
               rsp_wp_in   = 1'b0;
               rsp_last_in = 1'b0;
            end
         end else begin
            rank_in[slot_ff] = scan_ff[RW-1:0] - fired_ff[RW-1:0];
         end
         scan_in = scan_ff + 1'b1;
      end

      if (cmd.finish) begin
         cnt_in      = cnt_ff - fired_ff;
         hold_vld_in = 1'b0;
         rsp_vld_in  = 1'b1;
         rsp_wp_in   = 1'b0;
         rsp_last_in = 1'b1;
         if (hold_vld_ff) begin
            rsp_kind_in = ttace_pkg::KIND_FIRED;
            rsp_slot_in = ttace_pkg::ID_W'(hold_slot_ff);
         end else begin
            rsp_kind_in = ttace_pkg::KIND_NONE;
            rsp_slot_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         rank_ff     <= '{default: '0};
         cnt_ff      <= '0;
         scan_ff     <= '0;
         fired_ff    <= '0;
         hold_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         pending_ff  <= pending_in;
         rank_ff     <= rank_in;
         cnt_ff      <= cnt_in;
         scan_ff     <= scan_in;
         fired_ff    <= fired_in;
         hold_vld_ff <= hold_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      slot_ff      <= slot_in;
      hold_slot_ff <= hold_slot_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_wp_ff    <= rsp_wp_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe        = rsp_vld_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_slot_id       = rsp_slot_ff;
   assign rsp_prior_pending = rsp_wp_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

/* sv/timer_table_arm_cancel_expire_unit.sv */
// Timer slot table. A transaction is taken when start is high and busy is low. Arm and
// cancel keep busy low, and the acknowledge appears on the rsp_ ports in the next cycle.
// A poll raises busy until the scan has passed every slot that was pending when it
// started: the scan walks the slots newest-armed first, with one expiry memory read in the
// look state and one wraparound compare in the check state per slot. Fired results come
// out during the scan, the final one (or the none-due result) in the first cycle with busy
// low again. Every result is shown for exactly one cycle with rsp_strobe and cannot be
// held off by the receiver. Opcode 3 is taken and ignored. No clearing pass follows reset.
module timer_table_arm_cancel_expire_unit #(
   parameter int NUM_SLOTS = ttace_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_opcode,
   input  logic [ttace_pkg::ID_W-1:0]    req_timer_id,
   input  logic [ttace_pkg::TICK_W-1:0]  req_expiry_time,
   input  logic [ttace_pkg::TICK_W-1:0]  req_now_ticks,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_kind,
   output logic [ttace_pkg::ID_W-1:0]    rsp_slot_id,
   output logic                          rsp_prior_pending,
   output logic                          rsp_last
);

   ttace_pkg::ctl_cmd_type    cmd;
   ttace_pkg::ctl_status_type status;

   ttace_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_opcode),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ttace_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_timer_id      (req_timer_id),
      .req_expiry_time   (req_expiry_time),
      .req_now_ticks     (req_now_ticks),
      .rsp_strobe        (rsp_strobe),
      .rsp_kind          (rsp_kind),
      .rsp_slot_id       (rsp_slot_id),
      .rsp_prior_pending (rsp_prior_pending),
      .rsp_last          (rsp_last)
   );

endmodule

/* sv/ttace_checker.sv */
module ttace_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [1:0]                    req_opcode,
   input logic [ttace_pkg::ID_W-1:0]    req_timer_id,
   input logic                          rsp_strobe,
   input logic [1:0]                    rsp_kind,
   input logic [ttace_pkg::ID_W-1:0]    rsp_slot_id,
   input logic                          rsp_prior_pending,
   input logic                          rsp_last
);

   a_arm_ack: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == ttace_pkg::OP_ARM |=>
         rsp_strobe && rsp_kind == ttace_pkg::KIND_ARM && rsp_last &&
         rsp_slot_id == $past(req_timer_id))
      else $error("arm not acknowledged in the next cycle");

   a_poll_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == ttace_pkg::OP_POLL |=> busy)
      else $error("poll did not raise busy");

   a_none_due: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_kind == ttace_pkg::KIND_NONE |->
         rsp_slot_id == '0 && !rsp_prior_pending && rsp_last)
      else $error("malformed none-due result");

   a_mid_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy && rsp_kind == ttace_pkg::KIND_FIRED)
      else $error("non-final result outside a poll scan");

endmodule

bind timer_table_arm_cancel_expire_unit ttace_checker u_ttace_checker (.*);
